FILE: hw/rtl/pe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pe_pkg: shared constants and helpers for the Potts energy engine
// Sizes of the coupling store, field widths and the coupling address map.
// ---------------------------------------------------------------------------
package pe_pkg;

  localparam int MAX_LENGTH     = 64;
  localparam int NUM_SYMBOLS    = 5;
  localparam int COUPLING_WIDTH = 24;

  localparam int POS_W    = 6;
  localparam int SYM_W    = 3;
  localparam int LEN_W    = 7;
  localparam int OP_W     = 2;
  localparam int CPL_IN_W = 24;
  localparam int ENERGY_W = 48;

  localparam int TBL_DEPTH = MAX_LENGTH * MAX_LENGTH * NUM_SYMBOLS * NUM_SYMBOLS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam logic [OP_W-1:0] OP_WRITE_CPL = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_SYM   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELTA     = 2'd2;
  localparam logic [OP_W-1:0] OP_TOTAL     = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [TBL_AW-1:0] taddr_t;

  // Table address of coupling J[i][j][a][b], i <= j.
  function automatic taddr_t cell_addr(pos_t i, pos_t j, sym_t a, sym_t b);
    int row;
    row = int'(i) * MAX_LENGTH + int'(j);
    return TBL_AW'((row * NUM_SYMBOLS + int'(a)) * NUM_SYMBOLS + int'(b));
  endfunction

  // Coupling between p (symbol sp) and q (symbol sq), lower position first.
  function automatic taddr_t pair_addr(pos_t p, sym_t sp, pos_t q, sym_t sq);
    taddr_t r;
    if (p <= q) begin
      r = cell_addr(p, q, sp, sq);
    end else begin
      r = cell_addr(q, p, sq, sp);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pe_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pe_if: request and result channels of the Potts energy engine
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface pe_req_if;
  import pe_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [POS_W-1:0]           pos_first;
  logic [POS_W-1:0]           pos_second;
  logic [SYM_W-1:0]           sym_first;
  logic [SYM_W-1:0]           sym_second;
  logic signed [CPL_IN_W-1:0] coupling_value;

  modport source (output valid, operation, pos_first, pos_second, sym_first,
                  sym_second, coupling_value, input ready);
  modport sink   (input valid, operation, pos_first, pos_second, sym_first,
                  sym_second, coupling_value, output ready);
endinterface

interface pe_rsp_if;
  import pe_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] energy_value;
  logic                       status;

  modport source (output valid, energy_value, status, input ready);
  modport sink   (input valid, energy_value, status, output ready);
endinterface

FILE: hw/rtl/potts_energy_delta_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// potts_energy_delta_engine: Potts coupling store with energy queries
// Holds couplings and the symbol sequence; answers deltas and totals.
// ---------------------------------------------------------------------------
// One request is taken at a time and each gives one result. Coupling writes,
// symbol sets and every request with a bad index answer without a walk. A
// mutation delta reads the old symbol and then walks all L positions, one
// position per cycle with both coupling terms read together on the two read
// ports of the coupling memory. A total walks every pair i <= j with one
// coupling read per cycle plus one symbol read per row. The walk length is
// set by the single symbol-memory read port and one coupling read per pair.
// No clearing pass runs after reset; memories are undefined until written.
module potts_energy_delta_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pe_pkg::LEN_W-1:0]  cfg_wdata,
  pe_req_if.sink                    in_ch,
  pe_rsp_if.source                  out_ch
);
  import pe_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HEAD  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // storage
  logic [COUPLING_WIDTH-1:0] cmem [TBL_DEPTH];
  sym_t                      smem [MAX_LENGTH];

  logic [LEN_W-1:0] seq_length_r;
  logic [1:0]       state_r, state_nxt;
  logic             is_total_r;
  pos_t             c_r, row_r, col_r;
  sym_t             n_r, si_r;

  // walk pipeline
  logic             s1_vld_r, s1_head_r, s1_last_r;
  pos_t             s1_p_r, s1_row_r;
  sym_t             seq_q;
  logic             s2_vld_r, s2_last_r, s2_useb_r;
  logic [COUPLING_WIDTH-1:0] rd_a_q, rd_b_q;
  logic signed [ENERGY_W-1:0] acc_r;

  logic             out_vld_r;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic             out_status_r;

  logic [LEN_W-1:0] len_w;
  logic             accept, bad_wr, bad_pos;
  logic             col_last, row_last;
  pos_t             seq_raddr;
  logic             issue, issue_head;
  pos_t             first_w;
  sym_t             sym_a, sp_a, sp_b;
  taddr_t           addr_a, addr_b;
  logic signed [ENERGY_W-1:0] term_w, sum_w;

  // effective length
  assign len_w = (seq_length_r > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : seq_length_r;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // request checks
  assign bad_pos = ({1'b0, in_ch.pos_first} >= len_w) ||
                   (in_ch.sym_first >= SYM_W'(NUM_SYMBOLS));
  assign bad_wr  = bad_pos || ({1'b0, in_ch.pos_second} >= len_w) ||
                   (in_ch.pos_first > in_ch.pos_second) ||
                   (in_ch.sym_second >= SYM_W'(NUM_SYMBOLS));

  assign col_last = ({1'b0, col_r} == len_w - LEN_W'(1));
  assign row_last = ({1'b0, row_r} == len_w - LEN_W'(1));

  // symbol read issue
  assign issue_head = (state_r == ST_HEAD);
  assign issue      = (state_r == ST_WALK);
  always_comb begin
    seq_raddr = col_r;
    if (issue_head) begin
      seq_raddr = is_total_r ? row_r : c_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !bad_pos && in_ch.operation == OP_DELTA) begin
          state_nxt = ST_HEAD;
        end else if (accept && in_ch.operation == OP_TOTAL && len_w != '0) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: state_nxt = ST_WALK;
      ST_WALK: begin
        if (col_last) begin
          state_nxt = (is_total_r && !row_last) ? ST_HEAD : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_vld_r && s2_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seq_length_r <= LEN_W'(MAX_LENGTH);
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        seq_length_r <= cfg_wdata;
      end
      s1_vld_r <= issue_head || issue;
      s2_vld_r <= s1_vld_r && !s1_head_r;
      if (accept && !(state_nxt == ST_HEAD)) begin
        out_vld_r <= 1'b1;
      end else if (state_r == ST_DRAIN && s2_vld_r && s2_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // request capture and walk counters
  always_ff @(posedge clk) begin
    if (accept) begin
      is_total_r <= (in_ch.operation == OP_TOTAL);
      c_r        <= in_ch.pos_first;
      n_r        <= in_ch.sym_first;
      row_r      <= '0;
      col_r      <= '0;
    end else if (issue_head) begin
      col_r <= is_total_r ? row_r : '0;
    end else if (issue) begin
      if (col_last) begin
        row_r <= row_r + POS_W'(1);
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  // stage 1: symbol memory read
  always_ff @(posedge clk) begin
    seq_q     <= smem[seq_raddr];
    s1_head_r <= issue_head;
    s1_last_r <= issue && col_last && !(is_total_r && !row_last);
    s1_p_r    <= col_r;
    s1_row_r  <= row_r;
    if (s1_vld_r && s1_head_r) begin
      si_r <= seq_q;
    end
  end

  // coupling addresses for the new and old term
  always_comb begin
    first_w = is_total_r ? s1_row_r : c_r;
    sym_a   = is_total_r ? si_r : n_r;
    sp_a    = (!is_total_r && s1_p_r == c_r) ? n_r : seq_q;
    sp_b    = (s1_p_r == c_r) ? si_r : seq_q;
    addr_a  = pair_addr(first_w, sym_a, s1_p_r, sp_a);
    addr_b  = pair_addr(c_r, si_r, s1_p_r, sp_b);
  end

  // stage 2: coupling memory reads
  always_ff @(posedge clk) begin
    rd_a_q    <= cmem[addr_a];
    rd_b_q    <= cmem[addr_b];
    s2_last_r <= s1_last_r;
    s2_useb_r <= !is_total_r;
  end

  // accumulate
  always_comb begin
    term_w = ENERGY_W'(signed'(rd_a_q));
    if (s2_useb_r) begin
      term_w = term_w - ENERGY_W'(signed'(rd_b_q));
    end
    sum_w = acc_r + term_w;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= sum_w;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (accept && in_ch.operation == OP_WRITE_CPL && !bad_wr) begin
      cmem[cell_addr(in_ch.pos_first, in_ch.pos_second, in_ch.sym_first,
                     in_ch.sym_second)] <= in_ch.coupling_value[COUPLING_WIDTH-1:0];
    end
    if (accept && in_ch.operation == OP_SET_SYM && !bad_pos) begin
      smem[in_ch.pos_first] <= in_ch.sym_first;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_energy_r <= '0;
      case (in_ch.operation)
        OP_WRITE_CPL: out_status_r <= bad_wr ? STATUS_ERR : STATUS_OK;
        OP_TOTAL:     out_status_r <= STATUS_OK;
        default:      out_status_r <= bad_pos ? STATUS_ERR : STATUS_OK;
      endcase
    end else if (state_r == ST_DRAIN && s2_vld_r && s2_last_r) begin
      out_energy_r <= sum_w;
      out_status_r <= STATUS_OK;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.energy_value = out_energy_r;
  assign out_ch.status       = out_status_r;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE)
    else $error("request taken outside idle");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_vld_r && !s2_vld_r))
    else $error("walk pipeline busy in idle");

  a_delta_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == OP_DELTA && !bad_pos) |=> state_r == ST_HEAD)
    else $error("delta walk did not start");

  a_walk_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !in_ch.ready)
    else $error("ready during walk");
`endif

endmodule

FILE: bench/tb_potts_energy_delta_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_potts_energy_delta_engine: self-checking bench for the Potts engine
// Runs a directed table, then random coupling writes, symbol sets, deltas
// and totals over several sequence lengths against an in-bench energy
// tracker, with random idling on both channels and one long output stall.
// ---------------------------------------------------------------------------
module tb_potts_energy_delta_engine;
  import pe_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    pos_t                       p1;
    pos_t                       p2;
    sym_t                       s1;
    sym_t                       s2;
    logic signed [CPL_IN_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic                       status;
  } rsp_t;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t exp;
  } row_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  pe_req_if in_if ();
  pe_rsp_if out_if ();

  potts_energy_delta_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source)
  );

  always #5 clk = ~clk;

  // Energy tracker state
  logic signed [COUPLING_WIDTH-1:0] cpl_mem [TBL_DEPTH];
  bit                               cpl_known [TBL_DEPTH];
  sym_t                             seq_mem [MAX_LENGTH];
  bit                               seq_known [MAX_LENGTH];
  int unsigned                      len_reg = 64;

  rsp_t energy_q [$];
  row_t directed [$];
  int   errors = 0;
  int   in_idle = 0;
  int   out_idle = 0;
  int   stall_req = 0;
  int   stall_seen = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  task automatic report(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic int unsigned eff_len();
    return (len_reg < MAX_LENGTH) ? len_reg : MAX_LENGTH;
  endfunction

  function automatic int unsigned slot(int i, int j, int a, int b);
    return ((i * MAX_LENGTH + j) * NUM_SYMBOLS + a) * NUM_SYMBOLS + b;
  endfunction

  // Lower position first, its symbol first
  function automatic int unsigned link_slot(int p, int sp, int q, int sq);
    return (p <= q) ? slot(p, q, sp, sq) : slot(q, p, sq, sp);
  endfunction

  // Apply one request to the tracker and return its result
  function automatic rsp_t track_request(req_t r);
    rsp_t        o;
    longint      acc;
    int unsigned n;
    int          old;
    n   = eff_len();
    acc = 0;
    o.status = STATUS_OK;
    case (r.op)
      OP_WRITE_CPL: begin
        if (r.p1 >= n || r.p2 >= n || r.p1 > r.p2 ||
            r.s1 >= NUM_SYMBOLS || r.s2 >= NUM_SYMBOLS) begin
          o.status = STATUS_ERR;
        end else begin
          cpl_mem[slot(r.p1, r.p2, r.s1, r.s2)]   = r.val[COUPLING_WIDTH-1:0];
          cpl_known[slot(r.p1, r.p2, r.s1, r.s2)] = 1'b1;
        end
      end
      OP_SET_SYM: begin
        if (r.p1 >= n || r.s1 >= NUM_SYMBOLS) begin
          o.status = STATUS_ERR;
        end else begin
          seq_mem[r.p1]   = r.s1;
          seq_known[r.p1] = 1'b1;
        end
      end
      OP_DELTA: begin
        if (r.p1 >= n || r.s1 >= NUM_SYMBOLS) begin
          o.status = STATUS_ERR;
        end else begin
          old = seq_mem[r.p1];
          for (int p = 0; p < n; p++) begin
            if (p != r.p1) begin
              acc += cpl_mem[link_slot(r.p1, r.s1, p, seq_mem[p])];
              acc -= cpl_mem[link_slot(r.p1, old, p, seq_mem[p])];
            end
          end
          acc += cpl_mem[slot(r.p1, r.p1, r.s1, r.s1)];
          acc -= cpl_mem[slot(r.p1, r.p1, old, old)];
        end
      end
      default: begin
        for (int i = 0; i < n; i++)
          for (int j = i; j < n; j++)
            acc += cpl_mem[slot(i, j, seq_mem[i], seq_mem[j])];
      end
    endcase
    o.energy = acc[ENERGY_W-1:0];
    return o;
  endfunction

  function automatic req_t set_req(int p);
    req_t r;
    r = '0;
    r.op = OP_SET_SYM;
    r.p1 = pos_t'(p);
    r.s1 = sym_t'($urandom_range(0, NUM_SYMBOLS - 1));
    return r;
  endfunction

  function automatic req_t cpl_req(int i, int j, int a, int b);
    req_t r;
    r.op  = OP_WRITE_CPL;
    r.p1  = pos_t'(i);
    r.p2  = pos_t'(j);
    r.s1  = sym_t'(a);
    r.s2  = sym_t'(b);
    r.val = CPL_IN_W'($urandom());
    return r;
  endfunction

  // Replace a query that would read a never-written entry by the write
  // that fills the first such entry
  function automatic req_t fill_gaps(req_t r);
    int unsigned n;
    int          old;
    int          s;
    n = eff_len();
    if (r.op == OP_DELTA && r.p1 < n && r.s1 < NUM_SYMBOLS) begin
      if (!seq_known[r.p1]) return set_req(r.p1);
      old = seq_mem[r.p1];
      for (int p = 0; p < n; p++) begin
        if (p != r.p1) begin
          if (!seq_known[p]) return set_req(p);
          s = seq_mem[p];
          if (!cpl_known[link_slot(r.p1, r.s1, p, s)])
            return (r.p1 < p) ? cpl_req(r.p1, p, r.s1, s) : cpl_req(p, r.p1, s, r.s1);
          if (!cpl_known[link_slot(r.p1, old, p, s)])
            return (r.p1 < p) ? cpl_req(r.p1, p, old, s) : cpl_req(p, r.p1, s, old);
        end
      end
      if (!cpl_known[slot(r.p1, r.p1, r.s1, r.s1)])
        return cpl_req(r.p1, r.p1, r.s1, r.s1);
      if (!cpl_known[slot(r.p1, r.p1, old, old)])
        return cpl_req(r.p1, r.p1, old, old);
    end else if (r.op == OP_TOTAL) begin
      for (int i = 0; i < n; i++)
        if (!seq_known[i]) return set_req(i);
      for (int i = 0; i < n; i++)
        for (int j = i; j < n; j++)
          if (!cpl_known[slot(i, j, seq_mem[i], seq_mem[j])])
            return cpl_req(i, j, seq_mem[i], seq_mem[j]);
    end
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned n;
    int          pick;
    pos_t        t;
    n    = eff_len();
    pick = $urandom_range(0, 99);
    if (pick < 35) r.op = OP_WRITE_CPL;
    else if (pick < 55) r.op = OP_SET_SYM;
    else if (pick < 90 || n > 12) r.op = OP_DELTA;
    else r.op = OP_TOTAL;
    r.p1 = ($urandom_range(0, 9) != 0 && n > 0) ? pos_t'($urandom_range(0, n - 1))
                                                  : pos_t'($urandom());
    r.p2 = ($urandom_range(0, 9) != 0 && n > 0) ? pos_t'($urandom_range(0, n - 1))
                                                  : pos_t'($urandom());
    if (r.p1 > r.p2 && $urandom_range(0, 9) != 0) begin
      t    = r.p1;
      r.p1 = r.p2;
      r.p2 = t;
    end
    r.s1 = ($urandom_range(0, 9) != 0) ? sym_t'($urandom_range(0, 4)) : sym_t'($urandom());
    r.s2 = ($urandom_range(0, 9) != 0) ? sym_t'($urandom_range(0, 4)) : sym_t'($urandom());
    case ($urandom_range(0, 9))
      0:       r.val = {1'b1, {(CPL_IN_W-1){1'b0}}};
      1:       r.val = {1'b0, {(CPL_IN_W-1){1'b1}}};
      default: r.val = CPL_IN_W'($urandom());
    endcase
    return r;
  endfunction

  // Offer one request; return at the edge where it transfers
  task automatic send(req_t r, bit typed, rsp_t exp);
    rsp_t got;
    while ($urandom_range(0, 99) < in_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.operation      <= r.op;
    in_if.pos_first      <= r.p1;
    in_if.pos_second     <= r.p2;
    in_if.sym_first      <= r.s1;
    in_if.sym_second     <= r.s2;
    in_if.coupling_value <= r.val;
    do @(posedge clk); while (!in_if.ready);
    got = track_request(r);
    energy_q.push_back(typed ? exp : got);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_length(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= LEN_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_reg = v;
  endtask

  task automatic run_random(int count);
    rsp_t none;
    none = '0;
    for (int k = 0; k < count; k++) send(fill_gaps(random_req()), 1'b0, none);
  endtask

  task automatic add_row(logic [OP_W-1:0] op, int p1, int p2, int s1, int s2,
                         int val, bit typed, longint energy, logic status);
    row_t w;
    w.req   = '{op, pos_t'(p1), pos_t'(p2), sym_t'(s1), sym_t'(s2), CPL_IN_W'(val)};
    w.typed = typed;
    w.exp   = '{ENERGY_W'(energy), status};
    directed.push_back(w);
  endtask

  // Check results and drive ready; hold ready low for a requested stretch
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (energy_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = energy_q.pop_front();
        if (out_if.energy_value !== want.energy)
          report($sformatf("energy_value %0d, expected %0d",
                           out_if.energy_value, want.energy));
        if (out_if.status !== want.status)
          report($sformatf("status %0b, expected %0b", out_if.status, want.status));
      end
    end
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= out_idle);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid          = 1'b0;
    in_if.operation      = OP_WRITE_CPL;
    in_if.pos_first      = '0;
    in_if.pos_second     = '0;
    in_if.sym_first      = '0;
    in_if.sym_second     = '0;
    in_if.coupling_value = '0;
    out_if.ready         = 1'b0;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      cpl_mem[k]   = '0;
      cpl_known[k] = 1'b0;
    end
    for (int k = 0; k < MAX_LENGTH; k++) begin
      seq_mem[k]   = '0;
      seq_known[k] = 1'b0;
    end

    // Directed table, run at a single position
    add_row(OP_WRITE_CPL, 0, 0, 0, 0, 8388607, 1, 0, STATUS_OK);
    add_row(OP_WRITE_CPL, 1, 1, 0, 0, 5, 1, 0, STATUS_ERR);
    add_row(OP_WRITE_CPL, 0, 0, 5, 0, 5, 1, 0, STATUS_ERR);
    add_row(OP_WRITE_CPL, 0, 0, 0, 7, 5, 1, 0, STATUS_ERR);
    add_row(OP_WRITE_CPL, 0, 63, 0, 0, 5, 1, 0, STATUS_ERR);
    add_row(OP_WRITE_CPL, 63, 0, 4, 4, 5, 1, 0, STATUS_ERR);
    add_row(OP_WRITE_CPL, 0, 0, 4, 4, -8388608, 1, 0, STATUS_OK);
    add_row(OP_SET_SYM, 0, 0, 7, 0, 0, 1, 0, STATUS_ERR);
    add_row(OP_SET_SYM, 63, 0, 1, 0, 0, 1, 0, STATUS_ERR);
    add_row(OP_SET_SYM, 0, 0, 0, 0, 0, 1, 0, STATUS_OK);
    add_row(OP_TOTAL, 0, 0, 0, 0, 0, 1, 8388607, STATUS_OK);
    add_row(OP_DELTA, 0, 0, 4, 0, 0, 1, -16777215, STATUS_OK);
    add_row(OP_DELTA, 0, 0, 0, 0, 0, 1, 0, STATUS_OK);
    add_row(OP_DELTA, 0, 0, 5, 0, 0, 1, 0, STATUS_ERR);
    add_row(OP_DELTA, 63, 63, 1, 7, -1, 1, 0, STATUS_ERR);
    add_row(OP_SET_SYM, 0, 0, 4, 0, 0, 1, 0, STATUS_OK);
    add_row(OP_TOTAL, 63, 63, 7, 7, -1, 1, -8388608, STATUS_OK);
    add_row(OP_DELTA, 0, 0, 0, 0, 0, 1, 16777215, STATUS_OK);
    add_row(OP_WRITE_CPL, 0, 0, 4, 4, 'h5a5a5a, 1, 0, STATUS_OK);
    add_row(OP_TOTAL, 0, 0, 0, 0, 0, 0, 0, STATUS_OK);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, sender 31 / receiver 47 idle
    in_idle  = 31;
    out_idle = 47;
    set_length(1);
    foreach (directed[k]) send(directed[k].req, directed[k].typed, directed[k].exp);

    // Zero length: every index is out of range
    set_length(0);
    run_random(20);

    // Short sequence, deep random mix with one long output stall
    set_length(6);
    stall_req++;
    run_random(450);

    // Sender and receiver idling swapped, widest setting register value
    in_idle  = 47;
    out_idle = 31;
    set_length(127);
    run_random(200);

    set_length(3);
    run_random(200);

    // No idling
    in_idle  = 0;
    out_idle = 0;
    set_length(9);
    run_random(250);
    set_length(64);
    run_random(60);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
